### hdl/gcd_lcm_unit_macros.svh
// Assertion macros for the GCD/LCM unit.
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

// Checked only while out of reset.
`define GCL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define GCL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/gcl_pkg.sv
package gcl_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int SHIFT_W    = $clog2(DATA_WIDTH);
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int GCD_W      = 32;
    localparam int LCM_W      = 62;

    typedef logic [DATA_WIDTH-1:0]    data_t;
    typedef logic [SHIFT_W-1:0]       shift_t;
    typedef logic [PROD_W-1:0]        prod_t;
    typedef logic signed [GCD_W-1:0]  gcd_t;
    typedef logic [LCM_W-1:0]         lcm_t;
    typedef logic [1:0]               status_t;

    localparam status_t STATUS_NONE     = 2'd0;
    localparam status_t STATUS_GCD_ONLY = 2'd1;
    localparam status_t STATUS_BOTH     = 2'd2;

    function automatic data_t magnitude(data_t v);
        data_t m;
        m = v;
        if (v[DATA_WIDTH-1])
        begin
            m = data_t'(~v) + data_t'(1);
        end
        return m;
    endfunction

endpackage

### hdl/gcl_gcd_core.sv
module gcl_gcd_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  gcl_pkg::data_t x_in,
    input  gcl_pkg::data_t y_in,
    output logic           done,
    output gcl_pkg::data_t gcd
);

    localparam logic [1:0] G_IDLE  = 2'd0;
    localparam logic [1:0] G_TWOS  = 2'd1;
    localparam logic [1:0] G_XEVEN = 2'd2;
    localparam logic [1:0] G_LOOP  = 2'd3;

    logic [1:0]      state_reg, state_next;
    gcl_pkg::data_t  x_reg, x_next;
    gcl_pkg::data_t  y_reg, y_next;
    gcl_pkg::shift_t k_reg, k_next;
    gcl_pkg::data_t  gcd_reg, gcd_next;
    logic            done_reg, done_next;
    logic            x_gt_y;

    assign x_gt_y = (x_reg > y_reg);

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        k_next     = k_reg;
        gcd_next   = gcd_reg;
        done_next  = 1'b0;
        case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    x_next     = x_in;
                    y_next     = y_in;
                    k_next     = '0;
                    state_next = G_TWOS;
                end
            end
            G_TWOS:
            begin
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + gcl_pkg::shift_t'(1);
                end
                else
                begin
                    state_next = G_XEVEN;
                end
            end
            G_XEVEN:
            begin
                if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else
                begin
                    state_next = G_LOOP;
                end
            end
            G_LOOP:
            begin
                if (y_reg == '0)
                begin
                    gcd_next   = x_reg << k_reg;
                    done_next  = 1'b1;
                    state_next = G_IDLE;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_gt_y)
                begin
                    x_next = y_reg;
                    y_next = x_reg - y_reg;
                end
                else
                begin
                    y_next = y_reg - x_reg;
                end
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        gcd_reg <= gcd_next;
    end

    assign done = done_reg;
    assign gcd  = gcd_reg;

endmodule

### hdl/gcl_divider.sv
module gcl_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  gcl_pkg::data_t dividend,
    input  gcl_pkg::data_t divisor,
    output logic           done,
    output gcl_pkg::data_t quotient
);

    localparam int DW = gcl_pkg::DATA_WIDTH;

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    gcl_pkg::shift_t       cnt_reg, cnt_next;
    gcl_pkg::data_t        rem_reg, rem_next;
    gcl_pkg::data_t        quo_reg, quo_next;
    gcl_pkg::data_t        div_reg, div_next;
    logic [DW:0]           shifted;
    logic [DW+1:0]         trial;
    logic                  borrow;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};
    assign borrow  = trial[DW+1];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (!run_reg)
        begin
            if (start)
            begin
                run_next = 1'b1;
                cnt_next = gcl_pkg::shift_t'(DW - 1);
                rem_next = '0;
                quo_next = dividend;
                div_next = divisor;
            end
        end
        else
        begin
            rem_next = borrow ? shifted[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[DW-2:0], !borrow};
            cnt_next = cnt_reg - gcl_pkg::shift_t'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/gcd_lcm_unit.sv
// GCD and LCM of two signed operands. A request is taken when start is high
// and busy is low. Its result shows on status, gcd_value and lcm_value for
// exactly one cycle with done high, and the receiver cannot stall it. If
// either operand is zero, the result follows in the cycle after the request.
// Otherwise the binary GCD core runs first. It does one shift or one subtract
// per cycle, apart from its state changes. Every subtract but the last is
// followed by a shift. A restoring divider then computes |a|/gcd, and the
// product of that quotient with |b| is registered as the LCM. A new request
// can be taken in the cycle that done is high.
module gcd_lcm_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [31:0] first_value,
    input  logic signed [31:0] second_value,
    output logic              done,
    output logic [1:0]        status,
    output logic signed [31:0] gcd_value,
    output logic [61:0]       lcm_value
);

    localparam int DW = gcl_pkg::DATA_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GCD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_MUL  = 2'd3;

    logic [1:0]        state_reg, state_next;
    gcl_pkg::data_t    ma_reg, ma_next;
    gcl_pkg::data_t    mb_reg, mb_next;
    gcl_pkg::data_t    g_reg, g_next;
    logic              done_reg, done_next;
    gcl_pkg::status_t  status_reg, status_next;
    gcl_pkg::gcd_t     gcd_reg, gcd_next;
    gcl_pkg::lcm_t     lcm_reg, lcm_next;

    gcl_pkg::data_t    a, b, ma, mb;
    logic              accept;
    logic              gcd_start, gcd_done;
    gcl_pkg::data_t    gcd_res;
    logic              div_start, div_done;
    gcl_pkg::data_t    quo;
    gcl_pkg::prod_t    product;

    assign a      = first_value[DW-1:0];
    assign b      = second_value[DW-1:0];
    assign ma     = gcl_pkg::magnitude(a);
    assign mb     = gcl_pkg::magnitude(b);
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign gcd_start = accept && (a != '0) && (b != '0);
    assign div_start = (state_reg == S_GCD) && gcd_done;
    assign product   = gcl_pkg::prod_t'(quo) * gcl_pkg::prod_t'(mb_reg);

    gcl_gcd_core u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x_in  (ma),
        .y_in  (mb),
        .done  (gcd_done),
        .gcd   (gcd_res)
    );

    gcl_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ma_reg),
        .divisor  (gcd_res),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        state_next  = state_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        g_next      = g_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        gcd_next    = gcd_reg;
        lcm_next    = lcm_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (a == '0 && b == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = gcl_pkg::STATUS_NONE;
                        gcd_next    = '0;
                        lcm_next    = '0;
                    end
                    else if (a == '0 || b == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = gcl_pkg::STATUS_GCD_ONLY;
                        gcd_next    = gcl_pkg::gcd_t'($signed((a == '0) ? b : a));
                        lcm_next    = '0;
                    end
                    else
                    begin
                        ma_next    = ma;
                        mb_next    = mb;
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                if (gcd_done)
                begin
                    g_next     = gcd_res;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                done_next   = 1'b1;
                status_next = gcl_pkg::STATUS_BOTH;
                gcd_next    = gcl_pkg::gcd_t'(g_reg);
                lcm_next    = gcl_pkg::lcm_t'(product);
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        g_reg      <= g_next;
        status_reg <= status_next;
        gcd_reg    <= gcd_next;
        lcm_reg    <= lcm_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign gcd_value = gcd_reg;
    assign lcm_value = lcm_reg;

endmodule

### hdl/gcl_checker.sv
`include "gcd_lcm_unit_macros.svh"

module gcl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic signed [31:0] first_value,
    input logic signed [31:0] second_value,
    input logic              done,
    input logic [1:0]        status,
    input logic signed [31:0] gcd_value,
    input logic [61:0]       lcm_value
);

    localparam int DW = gcl_pkg::DATA_WIDTH;

    `GCL_ASSERT(a_done_idle, done |-> !busy, "result shown while busy")
    `GCL_ASSERT(a_busy_from_request, $rose(busy) |-> $past(start), "busy without request")
    `GCL_ASSERT(a_zero_pair, (start && !busy && first_value[DW-1:0] == '0 && second_value[DW-1:0] == '0) |=> (done && status == gcl_pkg::STATUS_NONE && gcd_value == '0 && lcm_value == '0), "zero pair result wrong")
    `GCL_ASSERT(a_lcm_zero, (done && status != gcl_pkg::STATUS_BOTH) |-> (lcm_value == '0), "lcm nonzero without both operands")
    `GCL_ASSERT(a_both_nonzero, (done && status == gcl_pkg::STATUS_BOTH) |-> (gcd_value != '0 && lcm_value != '0), "zero gcd or lcm for nonzero pair")

endmodule

bind gcd_lcm_unit gcl_checker u_checker (.*);

### tb/gcd_lcm_checker.sv
`timescale 1ns / 1ps

module gcd_lcm_checker
    import gcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [31:0]        first_value,
    input  logic [31:0]        second_value,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic signed [31:0] gcd_value,
    input  logic [61:0]        lcm_value,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        status_t     status;
        gcd_t        gcd;
        lcm_t        lcm;
    } gcd_lcm_result_t;

    gcd_lcm_result_t awaited_results[$];
    gcd_lcm_result_t oldest;
    int              mismatch_count = 0;
    int              queued_count   = 0;

    assign errors  = mismatch_count;
    assign pending = queued_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic gcd_lcm_result_t predict_gcd_lcm(logic [31:0] a_in, logic [31:0] b_in);
        gcd_lcm_result_t r;
        data_t           a;
        data_t           b;
        data_t           inv;
        prod_t           ma;
        prod_t           mb;
        prod_t           x;
        prod_t           y;
        prod_t           t;
        int unsigned     sh;
        a        = data_t'(a_in);
        b        = data_t'(b_in);
        r.a      = a_in;
        r.b      = b_in;
        r.status = STATUS_NONE;
        r.gcd    = '0;
        r.lcm    = '0;
        if (a != '0 && b != '0)
        begin
            ma = prod_t'(a);
            if (a[DATA_WIDTH-1])
            begin
                inv = ~a;
                ma  = prod_t'(inv) + prod_t'(1);
            end
            mb = prod_t'(b);
            if (b[DATA_WIDTH-1])
            begin
                inv = ~b;
                mb  = prod_t'(inv) + prod_t'(1);
            end
            x  = ma;
            y  = mb;
            sh = 0;
            while (x[0] == 1'b0 && y[0] == 1'b0)
            begin
                x  = x >> 1;
                y  = y >> 1;
                sh = sh + 1;
            end
            while (x[0] == 1'b0)
                x = x >> 1;
            while (y != '0)
            begin
                while (y[0] == 1'b0)
                    y = y >> 1;
                if (x > y)
                begin
                    t = x;
                    x = y;
                    y = t;
                end
                y = y - x;
            end
            x        = x << sh;
            r.status = STATUS_BOTH;
            r.gcd    = gcd_t'(x);
            r.lcm    = lcm_t'((ma / x) * mb);
        end
        else if (a != '0 || b != '0)
        begin
            // nonzero operand passes through unchanged as the signed gcd
            r.status = STATUS_GCD_ONLY;
            r.gcd    = gcd_t'($signed((a == '0) ? b : a));
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("unrequested result: status %0d gcd %0d lcm %0d",
                        status, gcd_value, lcm_value));
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (status !== oldest.status)
                        report_mismatch($sformatf("a=%0d b=%0d status %0d, want %0d",
                            $signed(oldest.a), $signed(oldest.b), status, oldest.status));
                    if (gcd_value !== oldest.gcd)
                        report_mismatch($sformatf("a=%0d b=%0d gcd %0d, want %0d",
                            $signed(oldest.a), $signed(oldest.b), gcd_value, oldest.gcd));
                    if (lcm_value !== oldest.lcm)
                        report_mismatch($sformatf("a=%0d b=%0d lcm %0d, want %0d",
                            $signed(oldest.a), $signed(oldest.b), lcm_value, oldest.lcm));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                awaited_results.push_back(predict_gcd_lcm(first_value, second_value));
            queued_count = awaited_results.size();
        end
    end

endmodule

### tb/gcd_lcm_unit_tb.sv
`timescale 1ns / 1ps

module gcd_lcm_unit_tb;
    import gcl_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] gcd_value;
    logic [61:0]        lcm_value;
    int                 errors;
    int                 pending;
    bit                 gaps_on = 1'b1;

    gcd_lcm_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_value  (first_value),
        .second_value (second_value),
        .done         (done),
        .status       (status),
        .gcd_value    (gcd_value),
        .lcm_value    (lcm_value)
    );

    gcd_lcm_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_value  (first_value),
        .second_value (second_value),
        .done         (done),
        .status       (status),
        .gcd_value    (gcd_value),
        .lcm_value    (lcm_value),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("DONE: errors detected");
        $finish;
    end

    // start drops at random while waiting if gaps_on is set; operands are scrambled when not offered
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        bit offer;
        do
        begin
            @(negedge clk);
            offer = !(gaps_on && $urandom_range(99) < 16);
            start        <= offer;
            first_value  <= offer ? a : $urandom;
            second_value <= offer ? b : $urandom;
            @(posedge clk);
        end
        while (!(offer && busy === 1'b0));
    endtask

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        int unsigned k;
        int unsigned m;
        int unsigned n;
        int          i;
        rst_n        = 1'b0;
        start        = 1'b0;
        first_value  = '0;
        second_value = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        send_pair(0, 0);
        send_pair(0, 5);
        send_pair(-7, 0);
        send_pair(0, 32'h8000_0000);
        send_pair(32'h7FFF_FFFF, 0);
        send_pair(1, 1);
        send_pair(-1, -1);
        send_pair(12, 18);
        send_pair(-12, 18);
        send_pair(12, -18);
        send_pair(-12, -18);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h8000_0001);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h8000_0000, 1);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(2147483647, 2147483629);
        send_pair(65536, 4096);
        send_pair(32'h4000_0000, 3 << 20);
        send_pair(1, 32'h7FFF_FFFF);
        send_pair(6, -4);
        send_pair(32'hFFFF_FFFF, 32'h8000_0000);

        for (i = 0; i < 450; i++)
        begin
            gaps_on = !(i >= 150 && i < 260);
            case ($urandom_range(9))
                0:
                begin
                    a = $urandom;
                    b = $urandom;
                end
                1, 2:
                begin
                    k = $urandom_range(65535, 1);
                    m = $urandom_range(32767, 1);
                    n = $urandom_range(32767, 1);
                    a = k * m;
                    b = k * n;
                end
                3:
                begin
                    a = ($urandom | 1) << $urandom_range(20);
                    b = ($urandom >> $urandom_range(31)) << $urandom_range(24);
                end
                4:
                begin
                    a = $urandom_range(3) == 0 ? 0 : $urandom >> $urandom_range(31);
                    b = $urandom_range(3) == 0 ? 0 : $urandom >> $urandom_range(31);
                    if ($urandom_range(1))
                        a = 0;
                    else
                        b = 0;
                end
                5:
                begin
                    a = $urandom_range(20);
                    b = $urandom_range(20);
                end
                6:
                begin
                    case ($urandom_range(5))
                        0: a = 32'h8000_0000;
                        1: a = 32'h7FFF_FFFF;
                        2: a = 32'h8000_0001;
                        3: a = 32'hFFFF_FFFF;
                        4: a = 1;
                        default: a = $urandom;
                    endcase
                    case ($urandom_range(5))
                        0: b = 32'h8000_0000;
                        1: b = 32'h7FFF_FFFF;
                        2: b = 32'h8000_0001;
                        3: b = 32'hFFFF_FFFF;
                        4: b = 1;
                        default: b = $urandom;
                    endcase
                end
                7:
                begin
                    b = ($urandom >> $urandom_range(31, 8)) | 1;
                    a = b * $urandom_range(255, 1);
                end
                default:
                begin
                    a = $urandom >> $urandom_range(31);
                    b = $urandom >> $urandom_range(31);
                end
            endcase
            if ($urandom_range(1))
                a = -a;
            if ($urandom_range(1))
                b = -b;
            if ($urandom_range(1))
            begin
                k = a;
                a = b;
                b = k;
            end
            send_pair(a, b);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (3 * DATA_WIDTH + 16) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/gcl_pkg.sv
hdl/gcl_gcd_core.sv
hdl/gcl_divider.sv
hdl/gcd_lcm_unit.sv
hdl/gcl_checker.sv
tb/gcd_lcm_checker.sv
tb/gcd_lcm_unit_tb.sv
